FILE: rtl/slipd_pkg.sv
// ----------------------------------------------------------------------------
// slipd_pkg
// Types and constants shared by the SLIP header deframer modules.
// ----------------------------------------------------------------------------
package slipd_pkg;

  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = 7;
  localparam int HDR_LEN     = 14;

  localparam logic [8:0] HDR_BYTES   = 9'd12;
  localparam logic [8:0] PAYLOAD_MIN = 9'd16;
  localparam logic [8:0] DATA_START  = 9'd14;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic                    fire;
    logic                    has_pay;
    logic [5:0]              data_n;
    logic [HDR_LEN-1:0][7:0] hdr;
  } frame_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  flags;
    logic [11:0] frag_offset;
    logic [7:0]  total_length;
    logic [15:0] ident;
    logic [7:0]  proto_number;
    logic [7:0]  header_sum;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [7:0]  command_or_data;
    logic [7:0]  payload_length;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD,
    ST_PAY
  } emit_state_t;

endpackage

FILE: rtl/slipd_if.sv
// ----------------------------------------------------------------------------
// slipd_if
// Valid/ready channels of the SLIP header deframer.
// ----------------------------------------------------------------------------
interface slipd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface slipd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  flags;
  logic [11:0] frag_offset;
  logic [7:0]  total_length;
  logic [15:0] ident;
  logic [7:0]  proto_number;
  logic [7:0]  header_sum;
  logic [15:0] src_addr;
  logic [15:0] dst_addr;
  logic [7:0]  command_or_data;
  logic [7:0]  payload_length;
  logic        last;

  modport source (output valid, output kind, output flags, output frag_offset,
                  output total_length, output ident, output proto_number,
                  output header_sum, output src_addr, output dst_addr,
                  output command_or_data, output payload_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input flags, input frag_offset,
                  input total_length, input ident, input proto_number,
                  input header_sum, input src_addr, input dst_addr,
                  input command_or_data, input payload_length, input last,
                  output ready);
endinterface

FILE: rtl/slipd_store.sv
// ----------------------------------------------------------------------------
// slipd_store
// Decoded byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slipd_store (
  input  logic                          clk,
  input  slipd_pkg::store_wr_t          wr,
  input  logic                          rd_en,
  input  logic [slipd_pkg::ADDR_W-1:0]  rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [slipd_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/slipd_rx.sv
// ----------------------------------------------------------------------------
// slipd_rx
// SLIP unescape, byte count, header byte capture and frame-end detection.
// ----------------------------------------------------------------------------
module slipd_rx #(
  parameter int STORE_LIMIT = 500,
  parameter int MAX_PAYLOAD = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 mode,
  input  logic [7:0]           rx_byte,
  output slipd_pkg::store_wr_t wr,
  output slipd_pkg::frame_t    frame
);

  logic [8:0]                         count_r, count_nxt;
  logic                               esc_r, esc_nxt;
  logic [slipd_pkg::HDR_LEN-1:0][7:0] hdr_r;
  logic [7:0]                         dec;
  logic                               keep;
  logic [8:0]                         avail;
  logic [5:0]                         cap;
  logic [7:0]                         len;
  logic                               frame_fire;
  logic                               has_pay;
  logic [5:0]                         data_n;

  // Undo the escape on the incoming byte
  always_comb begin
    dec = rx_byte;
    if (esc_r && rx_byte == slipd_pkg::TFEND) begin
      dec = slipd_pkg::FEND;
    end else if (esc_r && rx_byte == slipd_pkg::TFESC) begin
      dec = slipd_pkg::FESC;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    esc_nxt    = esc_r;
    keep       = 1'b0;
    frame_fire = 1'b0;
    if (fire) begin
      if (mode) begin
        count_nxt = '0;
        esc_nxt   = 1'b0;
      end else if (rx_byte == slipd_pkg::FEND) begin
        if (count_r > slipd_pkg::HDR_BYTES) begin
          frame_fire = 1'b1;
          esc_nxt    = 1'b0;
        end
        count_nxt = '0;
      end else if (rx_byte == slipd_pkg::FESC) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (count_r < 9'(STORE_LIMIT)) begin
          keep      = 1'b1;
          count_nxt = count_r + 9'd1;
        end
      end
    end
  end

  assign wr = {keep && (count_r < 9'(slipd_pkg::STORE_DEPTH)),
               count_r[slipd_pkg::ADDR_W-1:0], dec};

  // Payload count: length byte capped by the limit and by bytes received
  always_comb begin
    len     = hdr_r[13];
    avail   = count_r - slipd_pkg::DATA_START;
    cap     = (len > 8'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : len[5:0];
    has_pay = (count_r >= slipd_pkg::PAYLOAD_MIN);
    if (!has_pay) begin
      data_n = '0;
    end else if (avail < {3'b000, cap}) begin
      data_n = avail[5:0];
    end else begin
      data_n = cap;
    end
  end

  assign frame = {frame_fire, has_pay, data_n, hdr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      esc_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      esc_r   <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < slipd_pkg::HDR_LEN; i++) begin
      if (keep && count_r == 9'(i)) begin
        hdr_r[i] <= dec;
      end
    end
  end

endmodule

FILE: rtl/slipd_emit.sv
// ----------------------------------------------------------------------------
// slipd_emit
// Result sequencer: header result, then payload bytes read from the store.
// ----------------------------------------------------------------------------
module slipd_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slipd_pkg::frame_t             frame,
  output logic                          busy,
  output logic                          rd_en,
  output logic [slipd_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slipd_pkg::result_t            res
);

  slipd_pkg::emit_state_t state_r, state_nxt;
  logic [5:0]             data_n_r;
  logic                   has_pay_r;
  logic [5:0]             k_r;
  logic                   out_valid_r;
  slipd_pkg::result_t     res_r;
  logic                   slot_free;
  logic                   load_hdr;
  logic                   load_pay;
  logic                   final_pay;
  logic [8:0]             addr_full;

  assign slot_free = !out_valid_r || out_ready;
  assign final_pay = (k_r == data_n_r - 6'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slipd_pkg::ST_IDLE: begin
        if (frame.fire) state_nxt = slipd_pkg::ST_HDR;
      end
      slipd_pkg::ST_HDR: begin
        if (slot_free) begin
          state_nxt = (data_n_r == '0) ? slipd_pkg::ST_IDLE : slipd_pkg::ST_RD;
        end
      end
      slipd_pkg::ST_RD: begin
        state_nxt = slipd_pkg::ST_PAY;
      end
      slipd_pkg::ST_PAY: begin
        if (slot_free) begin
          state_nxt = final_pay ? slipd_pkg::ST_IDLE : slipd_pkg::ST_RD;
        end
      end
      default: state_nxt = slipd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != slipd_pkg::ST_IDLE);
    rd_en     = (state_r == slipd_pkg::ST_RD);
    addr_full = slipd_pkg::DATA_START + {3'b000, k_r};
    rd_addr   = addr_full[slipd_pkg::ADDR_W-1:0];
    load_hdr  = (state_r == slipd_pkg::ST_HDR) && slot_free;
    load_pay  = (state_r == slipd_pkg::ST_PAY) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slipd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      data_n_r    <= '0;
      has_pay_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_hdr || load_pay) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == slipd_pkg::ST_IDLE && frame.fire) begin
        k_r       <= '0;
        data_n_r  <= frame.data_n;
        has_pay_r <= frame.has_pay;
      end else if (load_pay) begin
        k_r <= k_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) begin
      res_r.kind            <= slipd_pkg::KIND_HDR;
      res_r.flags           <= frame.hdr[0][3:0] & slipd_pkg::NIBBLE_MASK;
      res_r.frag_offset     <= {frame.hdr[1], frame.hdr[0][7:4]};
      res_r.total_length    <= frame.hdr[2];
      res_r.ident           <= {frame.hdr[5], frame.hdr[4]};
      res_r.proto_number    <= frame.hdr[6];
      res_r.header_sum      <= frame.hdr[7];
      res_r.src_addr        <= {frame.hdr[9], frame.hdr[8]};
      res_r.dst_addr        <= {frame.hdr[11], frame.hdr[10]};
      res_r.command_or_data <= has_pay_r ? frame.hdr[12] : 8'd0;
      res_r.payload_length  <= has_pay_r ? frame.hdr[13] : 8'd0;
      res_r.last            <= (data_n_r == '0);
    end else if (load_pay) begin
      res_r.kind            <= slipd_pkg::KIND_PAY;
      res_r.flags           <= '0;
      res_r.frag_offset     <= '0;
      res_r.total_length    <= '0;
      res_r.ident           <= '0;
      res_r.proto_number    <= '0;
      res_r.header_sum      <= '0;
      res_r.src_addr        <= '0;
      res_r.dst_addr        <= '0;
      res_r.command_or_data <= rd_data;
      res_r.payload_length  <= '0;
      res_r.last            <= final_pay;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/slip_header_deframer.sv
// ----------------------------------------------------------------------------
// slip_header_deframer
// SLIP receive deframer: unescapes serial bytes, keeps them in a byte
// memory and on frame end reports one header result and the payload bytes.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer carries
//  --------  ---------  ----------------------------------------------------
//  in_ch     sink       mode, rx_byte (one raw serial byte or a purge)
//  out_ch    source     kind, header fields, command_or_data, last
//
//  Bytes and purges stream at one a cycle while no frame is being reported.
//  A frame end that yields results holds off input while the header result
//  and then each payload byte (store read, then output register load) are
//  sent; the single store read port sets the payload pace.
//  Reset is synchronous and clears the count, the escape flag and the
//  sequencer; the byte memory is not cleared. A stalled out_ch holds the
//  output register and the sequencer, and with them the input; once the
//  last result of a frame is loaded, bytes are taken again while it waits.
// ----------------------------------------------------------------------------
module slip_header_deframer #(
  parameter int STORE_LIMIT = 500,
  parameter int MAX_PAYLOAD = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  slipd_in_if.sink     in_ch,
  slipd_out_if.source  out_ch
);

  slipd_pkg::store_wr_t           wr;
  slipd_pkg::frame_t              frame;
  slipd_pkg::result_t             res;
  logic                           busy;
  logic                           rd_en;
  logic [slipd_pkg::ADDR_W-1:0]   rd_addr;
  logic [7:0]                     rd_data;
  logic                           in_fire;
  logic                           out_valid;

  // Take input only while no frame is being reported
  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;

  // Decode, count and capture header bytes
  slipd_rx #(
    .STORE_LIMIT (STORE_LIMIT),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .mode    (in_ch.mode),
    .rx_byte (in_ch.rx_byte),
    .wr      (wr),
    .frame   (frame)
  );

  // Decoded byte memory
  slipd_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Walk the header and payload out through the output register
  slipd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = res.kind;
  assign out_ch.flags           = res.flags;
  assign out_ch.frag_offset     = res.frag_offset;
  assign out_ch.total_length    = res.total_length;
  assign out_ch.ident           = res.ident;
  assign out_ch.proto_number    = res.proto_number;
  assign out_ch.header_sum      = res.header_sum;
  assign out_ch.src_addr        = res.src_addr;
  assign out_ch.dst_addr        = res.dst_addr;
  assign out_ch.command_or_data = res.command_or_data;
  assign out_ch.payload_length  = res.payload_length;
  assign out_ch.last            = res.last;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SLIP header deframer. Raw serial bytes and
// purges are sent on in_ch. A local model of the unescaping, the byte store
// and the header/payload sequencing predicts every out_ch transfer. Each
// transfer is compared field by field with the oldest prediction. Directed
// tests cover field extremes and the corner cases of framing. A random phase
// then sends mostly well-formed frames, with noise and aborted frames mixed
// in. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STORE_LIMIT = 500;
  localparam int MAX_PAYLOAD = 63;

  // Input item codes: a received byte or a purge of the receive state
  localparam logic MODE_RX    = 1'b0;
  localparam logic MODE_PURGE = 1'b1;

  localparam int RANDOM_ITEMS = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  slipd_in_if  in_ch ();
  slipd_out_if out_ch ();

  slip_header_deframer #(
    .STORE_LIMIT (STORE_LIMIT),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the receive state
  logic [7:0] rx_store [slipd_pkg::STORE_DEPTH];
  logic [8:0] rx_count;
  logic       rx_esc;

  // Frame results predicted but not yet seen on out_ch, oldest first
  slipd_pkg::result_t pending_results[$];

  int         fail_count  = 0;
  int         items_sent  = 0;
  int         cycle_count = 0;
  bit         in_idle_on   = 1'b1;
  bit         out_stall_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a run that hangs. The limit is several times the slowest run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Build the header result and the payload results for the stored frame.
  function automatic void push_frame_results();
    slipd_pkg::result_t hdr;
    slipd_pkg::result_t pay;
    int                 data_n;
    int                 avail;
    logic [8:0]         pos;
    hdr                 = '0;
    hdr.kind            = slipd_pkg::KIND_HDR;
    hdr.flags           = rx_store[0][3:0];
    hdr.frag_offset     = {rx_store[1], rx_store[0][7:4]};
    hdr.total_length    = rx_store[2];
    hdr.ident           = {rx_store[5], rx_store[4]};
    hdr.proto_number    = rx_store[6];
    hdr.header_sum      = rx_store[7];
    hdr.src_addr        = {rx_store[9], rx_store[8]};
    hdr.dst_addr        = {rx_store[11], rx_store[10]};
    data_n              = 0;
    // Report command and length only once the length byte is followed by at least two data bytes
    if (rx_count >= slipd_pkg::PAYLOAD_MIN) begin
      avail               = int'(rx_count) - int'(slipd_pkg::DATA_START);
      hdr.command_or_data = rx_store[12];
      hdr.payload_length  = rx_store[13];
      data_n              = int'(rx_store[13]);
      if (data_n > MAX_PAYLOAD) data_n = MAX_PAYLOAD;
      if (data_n > avail) data_n = avail;
    end
    hdr.last = (data_n == 0);
    pending_results.push_back(hdr);
    for (int k = 0; k < data_n; k++) begin
      pos                 = slipd_pkg::DATA_START + 9'(k);
      pay                 = '0;
      pay.kind            = slipd_pkg::KIND_PAY;
      pay.command_or_data = rx_store[pos[slipd_pkg::ADDR_W-1:0]];
      pay.last            = (k + 1 == data_n);
      pending_results.push_back(pay);
    end
  endfunction

  // Advance the local receive state by one accepted input item.
  function automatic void deframe_step(input logic m, input logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (m == MODE_PURGE) begin
      rx_count = '0;
      rx_esc   = 1'b0;
      return;
    end
    if (b == slipd_pkg::FEND) begin
      // A short frame leaves the escape flag as it stands
      if (rx_count > slipd_pkg::HDR_BYTES) begin
        push_frame_results();
        rx_esc = 1'b0;
      end
      rx_count = '0;
    end else if (b == slipd_pkg::FESC) begin
      rx_esc = 1'b1;
    end else begin
      if (rx_esc) begin
        if (b == slipd_pkg::TFEND) b = slipd_pkg::FEND;
        else if (b == slipd_pkg::TFESC) b = slipd_pkg::FESC;
        rx_esc = 1'b0;
      end
      // Count up to the limit; keep only what fits in the store
      if (rx_count < STORE_LIMIT) begin
        if (rx_count < slipd_pkg::STORE_DEPTH) begin
          rx_store[rx_count[slipd_pkg::ADDR_W-1:0]] = b;
        end
        rx_count = rx_count + 9'd1;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Send one item and hold it until the transfer. Valid stays high after the
  // transfer, so a back-to-back item is never lowered and raised in one step.
  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deframe_step(m, b);
    items_sent++;
  endtask

  // Send one decoded byte, escaping the two reserved codes.
  task automatic send_decoded(input logic [7:0] b);
    if (b == slipd_pkg::FEND) begin
      send_item(MODE_RX, slipd_pkg::FESC);
      send_item(MODE_RX, slipd_pkg::TFEND);
    end else if (b == slipd_pkg::FESC) begin
      send_item(MODE_RX, slipd_pkg::FESC);
      send_item(MODE_RX, slipd_pkg::TFESC);
    end else begin
      send_item(MODE_RX, b);
    end
  endtask

  task automatic send_frame(input byte_q_t body);
    foreach (body[i]) send_decoded(body[i]);
    send_item(MODE_RX, slipd_pkg::FEND);
  endtask

  // Random frame content, biased towards the SLIP control codes.
  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       b = slipd_pkg::FEND;
          1:       b = slipd_pkg::FESC;
          2:       b = slipd_pkg::TFEND;
          default: b = slipd_pkg::TFESC;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      q.push_back(b);
    end
    return q;
  endfunction

  function automatic byte_q_t filled_body(input int n, input logic [7:0] b);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(b);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    slipd_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0h, command_or_data %0h, last %0h",
             out_ch.kind, out_ch.command_or_data, out_ch.last);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(out_ch.kind));
      check_field("flags", 16'(want.flags), 16'(out_ch.flags));
      check_field("frag_offset", 16'(want.frag_offset),
                  16'(out_ch.frag_offset));
      check_field("total_length", 16'(want.total_length),
                  16'(out_ch.total_length));
      check_field("ident", want.ident, out_ch.ident);
      check_field("proto_number", 16'(want.proto_number),
                  16'(out_ch.proto_number));
      check_field("header_sum", 16'(want.header_sum),
                  16'(out_ch.header_sum));
      check_field("src_addr", want.src_addr, out_ch.src_addr);
      check_field("dst_addr", want.dst_addr, out_ch.dst_addr);
      check_field("command_or_data", 16'(want.command_or_data),
                  16'(out_ch.command_or_data));
      check_field("payload_length", 16'(want.payload_length),
                  16'(out_ch.payload_length));
      check_field("last", 16'(want.last), 16'(out_ch.last));
    end
  endtask

  // Sink: stall for a random number of cycles before each result, then hold
  // ready until the transfer and check what arrived.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = out_stall_on ? $urandom_range(0, 9) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All-ones and all-zero headers; the ones frame asks for 255 payload bytes
  // but carries two, the zero frame is too short for any payload.
  task automatic test_header_extremes();
    send_frame(filled_body(16, 8'hFF));
    send_frame(filled_body(13, 8'h00));
  endtask

  // Frame ends with 12 bytes or fewer give nothing. An escape before such an
  // end survives it and applies to the next byte.
  task automatic test_short_frame();
    byte_q_t body;
    send_item(MODE_RX, slipd_pkg::FEND);
    send_frame(random_body(12));
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_RX, slipd_pkg::FEND);
    send_item(MODE_RX, slipd_pkg::TFEND);
    body = random_body(12);
    send_frame(body);
  endtask

  task automatic test_escapes();
    byte_q_t body;
    send_decoded(slipd_pkg::FEND);
    send_decoded(slipd_pkg::FESC);
    // Escape followed by an ordinary byte keeps the byte as it is
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_RX, 8'h41);
    // Escape twice, then the escaped escape code
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_RX, slipd_pkg::TFESC);
    body = random_body(8);
    foreach (body[i]) send_decoded(body[i]);
    // Bare escape codes without a preceding escape are plain data
    send_item(MODE_RX, slipd_pkg::TFEND);
    send_item(MODE_RX, 8'd4);
    send_decoded(slipd_pkg::FEND);
    send_decoded(slipd_pkg::FESC);
    send_item(MODE_RX, slipd_pkg::TFEND);
    send_item(MODE_RX, slipd_pkg::TFESC);
    send_decoded(8'h5A);
    // An escape just before a reporting frame end is dropped with the frame
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_RX, slipd_pkg::FEND);
    send_item(MODE_RX, slipd_pkg::TFEND);
    send_frame(random_body(12));
  endtask

  // Payload count limited by the length byte and by the bytes actually
  // received; a zero length ends the frame on the header. The cap on the
  // count is covered by the overfilled frame.
  task automatic test_payload_caps();
    byte_q_t body;
    body = random_body(16);
    body[13] = 8'd0;
    send_frame(body);
    body = random_body(20);
    body[13] = 8'd3;
    send_frame(body);
    body = random_body(18);
    body[13] = 8'd10;
    send_frame(body);
    body = random_body(15);
    body[13] = 8'd1;
    send_frame(body);
  endtask

  // Overfill the store: the count holds at its limit, bytes past the store
  // depth are counted only, the length byte asks for more than the cap and
  // the next frame starts afresh.
  task automatic test_store_full();
    byte_q_t body;
    in_idle_on = 1'b0;
    body = filled_body(STORE_LIMIT + 2, 8'h5A);
    body[13] = 8'd200;
    send_frame(body);
    send_frame(random_body(20));
    in_idle_on = 1'b1;
  endtask

  // A purge drops a partial frame and a pending escape; its byte is ignored.
  task automatic test_purge();
    byte_q_t body;
    body = random_body(14);
    foreach (body[i]) send_decoded(body[i]);
    send_item(MODE_PURGE, slipd_pkg::FEND);
    send_item(MODE_RX, slipd_pkg::FEND);
    send_item(MODE_RX, slipd_pkg::FESC);
    send_item(MODE_PURGE, 8'($urandom_range(0, 255)));
    send_item(MODE_RX, slipd_pkg::TFEND);
    send_frame(random_body(15));
  endtask

  // Stray bytes, escapes, frame ends and purges between frames.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0:       send_item(MODE_PURGE, 8'($urandom_range(0, 255)));
        1:       send_item(MODE_RX, slipd_pkg::FESC);
        2:       send_item(MODE_RX, slipd_pkg::FEND);
        default: send_item(MODE_RX, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_random_frame();
    byte_q_t body;
    int      sel;
    int      n;
    int      cut;
    // Switch idling off for some frames to get stretches of full rate
    in_idle_on   = ($urandom_range(0, 3) != 0);
    out_stall_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 5) == 0) send_noise();
    sel = $urandom_range(0, 19);
    if (sel < 2) n = $urandom_range(0, 12);
    else if (sel < 4) n = $urandom_range(13, 15);
    else if (sel == 4) n = 14 + $urandom_range(40, 70);
    else n = 14 + $urandom_range(0, 16);
    body = random_body(n);
    if (n >= 14) begin
      if ($urandom_range(0, 3) == 0) body[13] = 8'($urandom_range(0, 255));
      else body[13] = 8'($urandom_range(0, n - 12));
    end
    if ($urandom_range(0, 15) == 0) begin
      // Abort part way with a purge
      cut = $urandom_range(0, n);
      for (int i = 0; i < cut; i++) send_decoded(body[i]);
      send_item(MODE_PURGE, 8'($urandom_range(0, 255)));
    end else begin
      send_frame(body);
    end
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) send_random_frame();
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
  endtask

  // Lower valid, drain the expected results, allow stray results to show.
  task automatic finish_run();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_RX;
    in_ch.rx_byte = 8'h00;
    rst_n         = 1'b0;
    rx_count      = '0;
    rx_esc        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_header_extremes();
    test_short_frame();
    test_escapes();
    test_payload_caps();
    test_purge();
    test_store_full();
    test_random();
    finish_run();
  end

endmodule

FILE: filelist.f
rtl/slipd_pkg.sv
rtl/slipd_if.sv
rtl/slipd_store.sv
rtl/slipd_rx.sv
rtl/slipd_emit.sv
rtl/slip_header_deframer.sv
tb/testbench.sv
